// ===== src/utf8_char_weight_accumulator_macros.svh =====
// Assertion helpers shared by the RTL.
// Every check samples on the rising edge of clock and is off while reset is high.
`ifndef UTF8_CHAR_WEIGHT_ACCUMULATOR_MACROS_SVH
`define UTF8_CHAR_WEIGHT_ACCUMULATOR_MACROS_SVH

// Same-cycle implication check
`define UCW_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Next-cycle check: cons must hold in the cycle after ante
`define UCW_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/utf8cw_pkg.sv =====
package utf8cw_pkg;

   // Field widths
   localparam int BYTE_WIDTH   = 8;
   localparam int CP_WIDTH     = 21;
   localparam int WEIGHT_WIDTH = 6;
   localparam int TOTAL_WIDTH  = 24;
   localparam int LEFT_WIDTH   = 2;

   // Width of the running weight sum (saturating)
   localparam int SUM_WIDTH = 24;

   // Payload masks for lead and continuation bytes
   localparam logic [BYTE_WIDTH-1:0] CONT_MASK  = 8'h3F;
   localparam logic [BYTE_WIDTH-1:0] LEAD2_MASK = 8'h1F;
   localparam logic [BYTE_WIDTH-1:0] LEAD3_MASK = 8'h0F;
   localparam logic [BYTE_WIDTH-1:0] LEAD4_MASK = 8'h07;

   // Bytes still expected after a lead byte
   localparam logic [LEFT_WIDTH-1:0] LEFT_NONE  = 2'd0;
   localparam logic [LEFT_WIDTH-1:0] LEFT_ONE   = 2'd1;
   localparam logic [LEFT_WIDTH-1:0] LEFT_TWO   = 2'd2;
   localparam logic [LEFT_WIDTH-1:0] LEFT_THREE = 2'd3;

   // Decoder result for the byte in the input register
   typedef struct packed {
      logic                emit;
      logic                last;
      logic [CP_WIDTH-1:0] code_point;
   } decode_type;

endpackage

// ===== src/utf8cw_decoder.sv =====
module utf8cw_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [utf8cw_pkg::BYTE_WIDTH-1:0]  text_byte,
   input  logic                               end_of_text,
   input  logic                               advance,
   output utf8cw_pkg::decode_type             dec_out
);
   import utf8cw_pkg::*;

   logic [CP_WIDTH-1:0]   partial_ff;
   logic [CP_WIDTH-1:0]   partial_in;
   logic [LEFT_WIDTH-1:0] left_ff;
   logic [LEFT_WIDTH-1:0] left_in;
   logic [CP_WIDTH-1:0]   point;
   logic [LEFT_WIDTH-1:0] left_next;
   logic                  emit;

   // Lead byte opens a sequence; otherwise append six payload bits
   always_comb begin
      if (left_ff == LEFT_NONE) begin
         if (text_byte[7] == 1'b0) begin
            point     = CP_WIDTH'(text_byte);
            left_next = LEFT_NONE;
         end else if (text_byte[7:5] == 3'b110) begin
            point     = CP_WIDTH'(text_byte & LEAD2_MASK);
            left_next = LEFT_ONE;
         end else if (text_byte[7:4] == 4'b1110) begin
            point     = CP_WIDTH'(text_byte & LEAD3_MASK);
            left_next = LEFT_TWO;
         end else begin
            point     = CP_WIDTH'(text_byte & LEAD4_MASK);
            left_next = LEFT_THREE;
         end
      end else begin
         point     = {partial_ff[CP_WIDTH-7:0], text_byte[5:0]};
         left_next = left_ff - LEFT_ONE;
      end
      emit = (left_next == LEFT_NONE) || end_of_text;
   end

   assign dec_out.emit       = emit;
   assign dec_out.last       = end_of_text;
   assign dec_out.code_point = point;

   // Close the sequence whenever a character goes out
   always_comb begin
      partial_in = partial_ff;
      left_in    = left_ff;
      if (advance) begin
         partial_in = emit ? '0 : point;
         left_in    = emit ? LEFT_NONE : left_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         left_ff    <= LEFT_NONE;
      end else begin
         partial_ff <= partial_in;
         left_ff    <= left_in;
      end
   end

endmodule

// ===== src/utf8cw_weigher.sv =====
module utf8cw_weigher (
   input  logic                                 clock,
   input  logic                                 reset,
   input  utf8cw_pkg::decode_type               dec_in,
   input  logic                                 advance,
   output logic [utf8cw_pkg::WEIGHT_WIDTH-1:0]  weight,
   output logic [utf8cw_pkg::TOTAL_WIDTH-1:0]   total
);
   import utf8cw_pkg::*;

   logic [SUM_WIDTH-1:0] sum_ff;
   logic [SUM_WIDTH-1:0] sum_in;
   logic [SUM_WIDTH:0]   sum_wide;
   logic [SUM_WIDTH-1:0] sum_sat;

   // Speaking weight in tenths by script range
   function automatic logic [WEIGHT_WIDTH-1:0] weight_of(input logic [CP_WIDTH-1:0] cp);
      logic [WEIGHT_WIDTH-1:0] w;
      if (cp inside {[21'h41:21'h5A], [21'h61:21'h7A]})            w = 6'd10;
      else if (cp == 21'h20)                                       w = 6'd2;
      else if (cp inside {[21'h30:21'h39]})                        w = 6'd35;
      else if (cp < 21'h80)                                        w = 6'd5;
      else if (cp inside {[21'h0900:21'h0903], [21'h093A:21'h094F],
                          [21'h0951:21'h0957], [21'h0962:21'h0963]}) w = 6'd0;
      else if (cp inside {[21'h0900:21'h0DFF]})                    w = 6'd18;
      else if (cp inside {[21'h0E00:21'h0EFF]})                    w = 6'd15;
      else if (cp inside {[21'h4E00:21'h9FFF]})                    w = 6'd30;
      else if (cp inside {[21'h0400:21'h04FF]})                    w = 6'd10;
      else if (cp inside {[21'h0600:21'h06FF]})                    w = 6'd15;
      else                                                         w = 6'd10;
      return w;
   endfunction

   // Saturating add: the carry out flags an overflow past the top
   always_comb begin
      weight   = weight_of(dec_in.code_point);
      sum_wide = {1'b0, sum_ff} + (SUM_WIDTH + 1)'(weight);
      sum_sat  = sum_wide[SUM_WIDTH] ? '1 : sum_wide[SUM_WIDTH-1:0];
      total    = TOTAL_WIDTH'(sum_sat);
   end

   // Total restarts after the last character of a text
   always_comb begin
      sum_in = sum_ff;
      if (advance && dec_in.emit) begin
         sum_in = dec_in.last ? '0 : sum_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== src/utf8_char_weight_accumulator.sv =====
// Lenient UTF-8 decoder with per-character speaking weights. One text byte is
// taken per transfer on req_ and every completed character (or the partial one
// left when end_of_text arrives) comes out on rsp_ with its weight in tenths and
// the saturating running total, which restarts after each final character.
// Throughput is one byte per clock unless the input register stalls as below. A
// transferred byte is loaded into the input register, then carried through the
// decoder and weight adder into the result register if it completes a character.
// While a result waits in the result register and rsp_ready is low, a byte
// that completes a character holds the input register and req_ready drops in
// the same cycle; bytes that complete no character still pass.
`include "utf8_char_weight_accumulator_macros.svh"

module utf8_char_weight_accumulator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [utf8cw_pkg::BYTE_WIDTH-1:0]   req_text_byte,
   input  logic                                req_end_of_text,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [utf8cw_pkg::CP_WIDTH-1:0]     rsp_code_point,
   output logic [utf8cw_pkg::WEIGHT_WIDTH-1:0] rsp_weight_tenths,
   output logic [utf8cw_pkg::TOTAL_WIDTH-1:0]  rsp_total_tenths,
   output logic                                rsp_final_char
);
   import utf8cw_pkg::*;

   logic                    s1_valid_ff;
   logic                    s1_valid_in;
   logic [BYTE_WIDTH-1:0]   s1_byte_ff;
   logic                    s1_last_ff;
   logic                    s1_advance;
   logic                    out_free;
   logic                    out_load;
   decode_type              dec;
   logic [WEIGHT_WIDTH-1:0] weight;
   logic [TOTAL_WIDTH-1:0]  total;

   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic [CP_WIDTH-1:0]     out_cp_ff;
   logic [WEIGHT_WIDTH-1:0] out_weight_ff;
   logic [TOTAL_WIDTH-1:0]  out_total_ff;
   logic                    out_final_ff;

   // Stage control: a byte that yields no character never waits on the output
   assign out_free    = !out_valid_ff || rsp_ready;
   assign s1_advance  = s1_valid_ff && (out_free || !dec.emit);
   assign out_load    = s1_advance && dec.emit;
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign s1_valid_in = req_ready ? req_valid : s1_valid_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_text_byte;
         s1_last_ff <= req_end_of_text;
      end
   end

   utf8cw_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .text_byte   (s1_byte_ff),
      .end_of_text (s1_last_ff),
      .advance     (s1_advance),
      .dec_out     (dec)
   );

   utf8cw_weigher u_weigher (
      .clock   (clock),
      .reset   (reset),
      .dec_in  (dec),
      .advance (s1_advance),
      .weight  (weight),
      .total   (total)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_cp_ff     <= dec.code_point;
         out_weight_ff <= weight;
         out_total_ff  <= total;
         out_final_ff  <= dec.last;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_code_point    = out_cp_ff;
   assign rsp_weight_tenths = out_weight_ff;
   assign rsp_total_tenths  = out_total_ff;
   assign rsp_final_char    = out_final_ff;

   // Checks
   `UCW_ASSERT(a_last_emits, (s1_valid_ff && s1_last_ff) |-> dec.emit, "end of text without a character")
   `UCW_ASSERT(a_total_covers_weight, rsp_valid |-> (rsp_total_tenths >= TOTAL_WIDTH'(rsp_weight_tenths)), "total below weight")
   `UCW_ASSERT_NEXT(a_stage_holds, s1_valid_ff && !s1_advance, s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_last_ff), "input stage lost a byte")

endmodule

// ===== tb/utf8_char_weight_accumulator_tb.sv =====
`timescale 1ns / 1ps

module utf8_char_weight_accumulator_tb;
   import utf8cw_pkg::*;

   localparam int CLOCK_PERIOD = 8;
   localparam int CYCLE_LIMIT  = 2_000_000;
   localparam int RANDOM_BYTES = 500;
   localparam int TAIL_CYCLES  = 10;
   localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

   typedef struct {
      logic [BYTE_WIDTH-1:0] text_byte;
      logic                  end_of_text;
      logic                  burst;   // no idling on either side while this goes out
      logic                  drain;   // wait for every pending character first
   } text_item_type;

   typedef struct {
      logic [CP_WIDTH-1:0]     code_point;
      logic [WEIGHT_WIDTH-1:0] weight_tenths;
      logic [TOTAL_WIDTH-1:0]  total_tenths;
      logic                    final_char;
   } char_record_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic [BYTE_WIDTH-1:0]   req_text_byte = '0;
   logic                    req_end_of_text = 1'b0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [CP_WIDTH-1:0]     rsp_code_point;
   logic [WEIGHT_WIDTH-1:0] rsp_weight_tenths;
   logic [TOTAL_WIDTH-1:0]  rsp_total_tenths;
   logic                    rsp_final_char;

   text_item_type   text_bytes[$];
   char_record_type pending_chars[$];

   // shadow decoder state
   logic [CP_WIDTH-1:0]   shadow_point = '0;
   logic [LEFT_WIDTH-1:0] shadow_left  = LEFT_NONE;
   logic [SUM_WIDTH-1:0]  shadow_sum   = '0;

   logic req_fire    = 1'b0;
   logic steady_mode = 1'b0;
   int   gap_left    = 0;
   int   stall_left  = 0;
   int   cycle_count = 0;
   int   mismatch_count = 0;
   int   bytes_sent  = 0;
   int   texts_done  = 0;
   int   chars_checked = 0;

   int unsigned boundary_points [0:30] = '{
      'h007F, 'h0080, 'h03FF, 'h0400, 'h04FF, 'h0500, 'h05FF, 'h0600, 'h06FF, 'h0700,
      'h08FF, 'h0900, 'h0903, 'h0904, 'h0939, 'h093A, 'h094F, 'h0950, 'h0951, 'h0957,
      'h0958, 'h0961, 'h0962, 'h0963, 'h0964, 'h0DFF, 'h0E00, 'h0EFF, 'h4DFF, 'h9FFF,
      'hA000};

   utf8_char_weight_accumulator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .req_end_of_text   (req_end_of_text),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_code_point    (rsp_code_point),
      .rsp_weight_tenths (rsp_weight_tenths),
      .rsp_total_tenths  (rsp_total_tenths),
      .rsp_final_char    (rsp_final_char)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // speaking weight of one character, in tenths
   function automatic logic [WEIGHT_WIDTH-1:0] expected_weight(input logic [CP_WIDTH-1:0] cp);
      if ((cp >= 'h41 && cp <= 'h5A) || (cp >= 'h61 && cp <= 'h7A)) return 6'd10;
      if (cp == 'h20) return 6'd2;
      if (cp >= 'h30 && cp <= 'h39) return 6'd35;
      if (cp < 'h80) return 6'd5;
      // Indic combining marks carry no weight
      if ((cp >= 'h0900 && cp <= 'h0903) || (cp >= 'h093A && cp <= 'h094F) ||
          (cp >= 'h0951 && cp <= 'h0957) || (cp >= 'h0962 && cp <= 'h0963)) return 6'd0;
      if (cp >= 'h0900 && cp <= 'h0DFF) return 6'd18;
      if (cp >= 'h0E00 && cp <= 'h0EFF) return 6'd15;
      if (cp >= 'h4E00 && cp <= 'h9FFF) return 6'd30;
      if (cp >= 'h0400 && cp <= 'h04FF) return 6'd10;
      if (cp >= 'h0600 && cp <= 'h06FF) return 6'd15;
      return 6'd10;
   endfunction

   // advance the shadow decoder by one byte; queue the character it completes
   task automatic decode_byte(input logic [BYTE_WIDTH-1:0] b, input logic last);
      char_record_type    rec;
      logic [SUM_WIDTH:0] grown;
      if (shadow_left == LEFT_NONE) begin
         if (b[7] == 1'b0) begin
            shadow_point = CP_WIDTH'(b);
         end else if (b[7:5] == 3'b110) begin
            shadow_point = CP_WIDTH'(b & LEAD2_MASK);
            shadow_left  = LEFT_ONE;
         end else if (b[7:4] == 4'b1110) begin
            shadow_point = CP_WIDTH'(b & LEAD3_MASK);
            shadow_left  = LEFT_TWO;
         end else begin
            // any other lead, stray continuation included, opens four bytes
            shadow_point = CP_WIDTH'(b & LEAD4_MASK);
            shadow_left  = LEFT_THREE;
         end
      end else begin
         // top bits of a sequence byte are not checked
         shadow_point = (shadow_point << 6) | CP_WIDTH'(b & CONT_MASK);
         shadow_left  = shadow_left - 1'b1;
      end

      if (shadow_left == LEFT_NONE || last) begin
         rec.code_point    = shadow_point;
         rec.weight_tenths = expected_weight(shadow_point);
         grown = {1'b0, shadow_sum} + rec.weight_tenths;
         if (grown > SUM_MAX) shadow_sum = SUM_MAX;
         else shadow_sum = grown[SUM_WIDTH-1:0];
         rec.total_tenths  = shadow_sum[TOTAL_WIDTH-1:0];
         rec.final_char    = last;
         pending_chars = {pending_chars, rec};
         shadow_point = '0;
         shadow_left  = LEFT_NONE;
         if (last) shadow_sum = '0;
      end
   endtask

   // idle stretch: mostly short, a few long
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return $urandom_range(1, 2);
      if (pick < 90) return $urandom_range(3, 8);
      return $urandom_range(15, 50);
   endfunction

   task automatic queue_byte(input logic [BYTE_WIDTH-1:0] b, input logic last,
                             input logic burst, input logic drain);
      text_item_type it;
      it.text_byte   = b;
      it.end_of_text = last;
      it.burst       = burst;
      it.drain       = drain;
      text_bytes = {text_bytes, it};
   endtask

   // encode a code point and queue its first keep bytes (0 keeps them all)
   task automatic queue_char(input logic [CP_WIDTH-1:0] cp, input int keep, input logic last,
                             input logic burst, input logic drain);
      logic [BYTE_WIDTH-1:0] enc [0:3];
      int n;
      if (cp < 'h80) begin
         n = 1;
         enc[0] = cp[7:0];
      end else if (cp < 'h800) begin
         n = 2;
         enc[0] = {3'b110, cp[10:6]};
         enc[1] = {2'b10, cp[5:0]};
      end else if (cp < 'h10000) begin
         n = 3;
         enc[0] = {4'b1110, cp[15:12]};
         enc[1] = {2'b10, cp[11:6]};
         enc[2] = {2'b10, cp[5:0]};
      end else begin
         n = 4;
         enc[0] = {5'b11110, cp[20:18]};
         enc[1] = {2'b10, cp[17:12]};
         enc[2] = {2'b10, cp[11:6]};
         enc[3] = {2'b10, cp[5:0]};
      end
      if (keep == 0 || keep > n) keep = n;
      for (int i = 0; i < keep; i++)
         queue_byte(enc[i], last && (i == keep - 1), burst, drain && (i == 0));
   endtask

   function automatic logic [CP_WIDTH-1:0] pick_point();
      int unsigned v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 'h7F);
         1: v = ($urandom_range(0, 1) ? 'h41 : 'h61) + $urandom_range(0, 25);
         2: v = 'h30 + $urandom_range(0, 9);
         3: v = 'h20;
         4: v = boundary_points[$urandom_range(0, 30)];
         5: v = 'h0900 + $urandom_range(0, 'h4FF);
         6: v = 'h4E00 + $urandom_range(0, 'h51FF);
         7: v = 'h0900 + $urandom_range(0, 'h6F);
         8: v = $urandom_range(0, 1) ? 'h0E00 + $urandom_range(0, 'hFF)
                                     : $urandom_range('h80, 'h7FF);
         default: v = $urandom_range(0, 'h1FFFFF);
      endcase
      return CP_WIDTH'(v);
   endfunction

   // driver: inputs change on the falling edge
   always @(negedge clock) begin : drive_side
      text_item_type cur;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // a byte on the bus stays put until its transfer
         if (!req_valid || req_fire) begin
            if (req_valid && $urandom_range(0, 99) >= 55) gap_left = idle_length();
            if (text_bytes.size() != 0 && (gap_left == 0 || text_bytes[0].burst) &&
                !(text_bytes[0].drain && pending_chars.size() != 0)) begin
               cur = text_bytes.pop_front();
               req_text_byte   <= cur.text_byte;
               req_end_of_text <= cur.end_of_text;
               req_valid       <= 1'b1;
               steady_mode = cur.burst;
            end else begin
               req_valid <= 1'b0;
               if (gap_left != 0) gap_left--;
            end
         end

         // result side backpressure
         if (steady_mode) begin
            rsp_ready <= 1'b1;
         end else if (stall_left != 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if ($urandom_range(0, 99) < 25) begin
            rsp_ready <= 1'b0;
            stall_left = idle_length() - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: sample both channels on the rising edge
   always @(posedge clock) begin : watch_side
      char_record_type want;
      cycle_count <= cycle_count + 1;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_chars.size() == 0) begin
               $error("unexpected character: code_point %0h total_tenths %0d",
                      rsp_code_point, rsp_total_tenths);
               mismatch_count++;
            end else begin
               want = pending_chars.pop_front();
               chars_checked++;
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %0h, got %0h", want.code_point, rsp_code_point);
                  mismatch_count++;
               end
               if (rsp_weight_tenths !== want.weight_tenths) begin
                  $error("weight_tenths: expected %0d, got %0d",
                         want.weight_tenths, rsp_weight_tenths);
                  mismatch_count++;
               end
               if (rsp_total_tenths !== want.total_tenths) begin
                  $error("total_tenths: expected %0d, got %0d",
                         want.total_tenths, rsp_total_tenths);
                  mismatch_count++;
               end
               if (rsp_final_char !== want.final_char) begin
                  $error("final_char: expected %0b, got %0b", want.final_char, rsp_final_char);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            bytes_sent++;
            if (req_end_of_text) texts_done++;
            decode_byte(req_text_byte, req_end_of_text);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int base;
      int n_chars;
      logic burst, drain, cut, last;

      // directed: ASCII classes and extremes
      queue_byte("A", 1'b0, 1'b0, 1'b0);
      queue_byte(" ", 1'b0, 1'b0, 1'b0);
      queue_byte("0", 1'b0, 1'b0, 1'b0);
      queue_byte("!", 1'b0, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b0, 1'b0, 1'b0);
      // multi-byte: Latin, Indic letter, Indic mark, CJK, top of the four-byte range
      queue_char('h00E9, 0, 1'b0, 1'b0, 1'b0);
      queue_char('h0939, 0, 1'b0, 1'b0, 1'b0);
      queue_char('h093E, 0, 1'b0, 1'b0, 1'b0);
      queue_char('h4E2D, 0, 1'b0, 1'b0, 1'b0);
      queue_char('h10FFFF, 0, 1'b0, 1'b0, 1'b0);
      // stray continuation opens four bytes, unchecked sequence bytes, text ends early
      queue_byte(8'h80, 1'b0, 1'b0, 1'b0);
      queue_byte(8'h3F, 1'b0, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b1, 1'b0, 1'b0);

      // one unbroken text sent back to back with the result side always ready
      for (int i = 0; i < 16; i++) queue_byte("9", 1'b0, 1'b1, i == 0);
      queue_byte("k", 1'b0, 1'b1, 1'b0);
      for (int i = 0; i < 4; i++) queue_byte("7", 1'b0, 1'b1, 1'b0);
      queue_byte(" ", 1'b0, 1'b1, 1'b0);
      queue_byte(".", 1'b1, 1'b1, 1'b0);

      // random texts: mostly well-formed, some noise bytes and truncated endings
      base = text_bytes.size();
      while (text_bytes.size() - base < RANDOM_BYTES) begin
         n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         burst = $urandom_range(0, 99) < 15;
         drain = (text_bytes.size() == base) || ($urandom_range(0, 99) < 4);
         cut   = $urandom_range(0, 99) < 12;
         for (int c = 0; c < n_chars; c++) begin
            last = (c == n_chars - 1);
            if ($urandom_range(0, 99) < 8)
               queue_byte(BYTE_WIDTH'($urandom_range(0, 255)), last, burst, drain && c == 0);
            else
               queue_char(pick_point(), (last && cut) ? $urandom_range(1, 3) : 0,
                          last, burst, drain && c == 0);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (text_bytes.size() != 0 || req_valid) @(posedge clock);
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d bytes in %0d texts; checked %0d characters.",
               bytes_sent, texts_done, chars_checked);
      $display("Stimulus mixed all script weight bands, noise bytes and early text ends.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
